FILE: rtl/core/mnss_pkg.sv
// Shared types, codes and constants of the motor node safety supervisor.
`timescale 1ns / 1ps
package mnss_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_ENC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_MASK   = 3'd4;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ESTOP = 2'd1;
    localparam logic [1:0] ACT_MOTOR = 2'd2;
    localparam logic [1:0] ACT_REQ   = 2'd3;

    localparam logic [2:0] CODE_ARM     = 3'd0;
    localparam logic [2:0] CODE_DISARM  = 3'd1;
    localparam logic [2:0] CODE_COMMIT  = 3'd2;
    localparam logic [2:0] CODE_RESTORE = 3'd3;
    localparam logic [2:0] CODE_FACTORY = 3'd4;
    localparam logic [2:0] CODE_RESET   = 3'd5;

    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [1:0] MODE_CODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_CODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_CODE_ERROR   = 2'd2;

    localparam int FLAG_OVERHEAT = 6;
    localparam int FLAG_TIMEOUT  = 7;

    localparam logic [15:0] RST_OVERHEAT_ON  = 16'sd1280;
    localparam logic [15:0] RST_OVERHEAT_OFF = 16'sd1120;
    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd1000;
    localparam logic [15:0] RST_CRIT_MASK    = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_TICK    = 3'd1,
        OP_ESTOP   = 3'd2,
        OP_MOTOR   = 3'd3,
        OP_ARM     = 3'd4,
        OP_DISARM  = 3'd5,
        OP_SERVICE = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        MODE_STOPPED = 3'b001,
        MODE_RUNNING = 3'b010,
        MODE_ERROR   = 3'b100
    } t_mode;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [5:0]  encoder_error;
        logic [7:0]  driver_error;
        logic [15:0] temperature;
        logic        sp_valid;
        logic [1:0]  sp_kind;
        logic [31:0] sp_value;
        logic [2:0]  service;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_beat;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] flags_out;
        logic        error_led;
        logic        stop_motor;
        logic        setpoint_valid;
        logic [1:0]  setpoint_kind;
        logic [31:0] setpoint_value;
        logic [2:0]  service_request;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        c = MODE_CODE_STOPPED;
        unique case (m)
            MODE_RUNNING: c = MODE_CODE_RUNNING;
            MODE_ERROR:   c = MODE_CODE_ERROR;
            default:      c = MODE_CODE_STOPPED;
        endcase
        return c;
    endfunction

    function automatic logic [Q_PTR_W-1:0] q_next(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

endpackage

FILE: rtl/core/motor_node_safety_supervisor_top.sv
// Top level of the motor node safety supervisor: front decoder and back executor.
// A beat is held in the front queue; its result is then registered in the result queue.
// Throughput: one beat per cycle unless stalled by a full queue; a two-entry queue
// sits between front and back, a two-entry result queue at the output, so each side stalls on its own.
// Reset (synchronous, active low): mode stopped, flags and timer zero, LED off,
// configuration at its defaults, both queues empty.
`timescale 1ns / 1ps
module motor_node_safety_supervisor_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_action,
    input  logic [31:0]         i_now_ms,
    input  logic [5:0]          i_encoder_error,
    input  logic [7:0]          i_driver_error,
    input  logic signed [15:0]  i_temperature,
    input  logic [2:0]          i_action_code,
    input  logic [1:0]          i_control_kind,
    input  logic signed [31:0]  i_command_value,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          o_mode,
    output logic [15:0]         o_flags_out,
    output logic                o_error_led,
    output logic                o_stop_motor,
    output logic                o_setpoint_valid,
    output logic [1:0]          o_setpoint_kind,
    output logic signed [31:0]  o_setpoint_value,
    output logic [2:0]          o_service_request,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [mnss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import mnss_pkg::*;

    t_item_beat w_beat;
    logic       w_take;
    t_result    w_result;

    mnss_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_now_ms        (i_now_ms),
        .i_encoder_error (i_encoder_error),
        .i_driver_error  (i_driver_error),
        .i_temperature   (i_temperature),
        .i_action_code   (i_action_code),
        .i_control_kind  (i_control_kind),
        .i_command_value (i_command_value),
        .o_beat          (w_beat),
        .i_take          (w_take)
    );

    mnss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_beat      (w_beat),
        .o_take      (w_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (w_result)
    );

    assign o_mode            = w_result.mode;
    assign o_flags_out       = w_result.flags_out;
    assign o_error_led       = w_result.error_led;
    assign o_stop_motor      = w_result.stop_motor;
    assign o_setpoint_valid  = w_result.setpoint_valid;
    assign o_setpoint_kind   = w_result.setpoint_kind;
    assign o_setpoint_value  = w_result.setpoint_value;
    assign o_service_request = w_result.service_request;

endmodule

FILE: rtl/core/mnss_front.sv
// Front end: accepts input beats, decodes them into operations, and queues them.
`timescale 1ns / 1ps
module mnss_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_now_ms,
    input  logic [5:0]         i_encoder_error,
    input  logic [7:0]         i_driver_error,
    input  logic [15:0]        i_temperature,
    input  logic [2:0]         i_action_code,
    input  logic [1:0]         i_control_kind,
    input  logic [31:0]        i_command_value,
    output mnss_pkg::t_item_beat o_beat,
    input  logic               i_take
);
    import mnss_pkg::*;

    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    t_item              w_item;
    logic               w_push, w_pop;

    always_comb begin
        w_item               = '0;
        w_item.op            = OP_NONE;
        w_item.now_ms        = i_now_ms;
        w_item.encoder_error = i_encoder_error;
        w_item.driver_error  = i_driver_error;
        w_item.temperature   = i_temperature;
        unique case (i_action)
            ACT_TICK:  w_item.op = OP_TICK;
            ACT_ESTOP: w_item.op = OP_ESTOP;
            ACT_MOTOR: begin
                w_item.op = OP_MOTOR;
                if (i_control_kind != KIND_IGNORED) begin
                    w_item.sp_valid = 1'b1;
                    w_item.sp_kind  = i_control_kind;
                    w_item.sp_value = i_command_value;
                end
            end
            default: begin
                unique case (i_action_code)
                    CODE_ARM:    w_item.op = OP_ARM;
                    CODE_DISARM: w_item.op = OP_DISARM;
                    CODE_COMMIT, CODE_RESTORE, CODE_FACTORY, CODE_RESET: begin
                        w_item.op      = OP_SERVICE;
                        w_item.service = i_action_code - 3'd1;
                    end
                    default:     w_item.op = OP_NONE;
                endcase
            end
        endcase
    end

    assign full   = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign w_push = push && !full;
    assign w_pop  = i_take && (r_cnt != '0);

    assign o_beat.valid = (r_cnt != '0);
    assign o_beat.item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= q_next(r_wptr);
            if (w_pop)  r_rptr <= q_next(r_rptr);
            if (w_push && !w_pop)      r_cnt <= r_cnt + Q_CNT_W'(1);
            else if (w_pop && !w_push) r_cnt <= r_cnt - Q_CNT_W'(1);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("front queue count beyond depth");
    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + Q_CNT_W'(1)))
        else $error("front queue count missed a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wptr == r_rptr))
        else $error("front queue pointers apart while empty");

endmodule

FILE: rtl/core/mnss_back.sv
// Back end: configuration, mode state machine, fault flags and the result queue.
`timescale 1ns / 1ps
module mnss_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [mnss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  mnss_pkg::t_item_beat  i_beat,
    output logic                  o_take,
    output logic                  empty,
    input  logic                  pop,
    output mnss_pkg::t_result     o_result
);
    import mnss_pkg::*;

    logic               r_ign_enc;
    logic [15:0]        r_oh_on, r_oh_off, r_tmo, r_mask;

    t_mode              r_mode, n_mode;
    logic [15:0]        r_flags, n_flags;
    logic [31:0]        r_last, n_last;
    logic               r_led, n_led;

    t_result            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_pop, w_room;

    t_item              w_it;
    t_result            w_res;
    logic [5:0]         w_enc;
    logic [15:0]        w_tick_flags;
    logic [31:0]        w_elapsed;
    logic               w_overheat, w_timeout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign_enc <= 1'b0;
            r_oh_on   <= RST_OVERHEAT_ON;
            r_oh_off  <= RST_OVERHEAT_OFF;
            r_tmo     <= RST_TIMEOUT_MS;
            r_mask    <= RST_CRIT_MASK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IGNORE_ENC:   r_ign_enc <= i_cfg_data[0];
                CFG_OVERHEAT_ON:  r_oh_on   <= i_cfg_data;
                CFG_OVERHEAT_OFF: r_oh_off  <= i_cfg_data;
                CFG_TIMEOUT_MS:   r_tmo     <= i_cfg_data;
                CFG_CRIT_MASK:    r_mask    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_pop  = pop && (r_cnt != '0);
    assign w_room = (r_cnt != Q_CNT_W'(Q_DEPTH)) || w_pop;
    assign o_take = i_beat.valid && w_room;
    assign w_it   = i_beat.item;

    assign w_enc     = r_ign_enc ? 6'd0 : w_it.encoder_error;
    assign w_elapsed = w_it.now_ms - r_last;
    assign w_timeout = (w_elapsed > {16'd0, r_tmo}) && (r_mode == MODE_RUNNING);

    always_comb begin
        w_overheat = r_flags[FLAG_OVERHEAT];
        if (r_flags[FLAG_OVERHEAT]) begin
            if ($signed(w_it.temperature) < $signed(r_oh_off)) w_overheat = 1'b0;
        end else if ($signed(w_it.temperature) > $signed(r_oh_on)) begin
            w_overheat = 1'b1;
        end
        w_tick_flags = {w_it.driver_error, w_timeout, w_overheat, w_enc};
    end

    always_comb begin
        n_mode = r_mode;
        n_flags = r_flags;
        n_last = r_last;
        n_led = r_led;
        w_res = '0;
        if (w_it.op == OP_TICK) begin
            n_flags = w_tick_flags;
            unique case (r_mode)
                MODE_RUNNING: begin
                    if (w_tick_flags != '0) begin
                        w_res.stop_motor = 1'b1;
                        if ((w_tick_flags & r_mask) != '0) begin
                            n_led  = 1'b1;
                            n_mode = MODE_ERROR;
                        end
                    end
                end
                MODE_ERROR: begin
                    if ((w_tick_flags & r_mask) == '0) begin
                        n_led  = 1'b0;
                        n_mode = MODE_RUNNING;
                        n_last = w_it.now_ms;
                    end
                end
                default: ;
            endcase
        end else begin
            unique case (r_mode)
                MODE_RUNNING: begin
                    if (w_it.op == OP_ESTOP || w_it.op == OP_DISARM) begin
                        w_res.stop_motor = 1'b1;
                        n_mode           = MODE_STOPPED;
                    end else if (w_it.op == OP_MOTOR) begin
                        n_last                = w_it.now_ms;
                        n_flags[FLAG_TIMEOUT] = 1'b0;
                        w_res.setpoint_valid  = w_it.sp_valid;
                        w_res.setpoint_kind   = w_it.sp_kind;
                        w_res.setpoint_value  = w_it.sp_value;
                    end
                end
                MODE_ERROR: begin
                    if (w_it.op == OP_DISARM) begin
                        n_led  = 1'b0;
                        n_mode = MODE_STOPPED;
                    end
                end
                default: begin
                    if (w_it.op == OP_ARM) begin
                        n_mode = MODE_RUNNING;
                        n_last = w_it.now_ms;
                    end else if (w_it.op == OP_SERVICE) begin
                        w_res.service_request = w_it.service;
                    end
                end
            endcase
        end
        w_res.mode      = mode_code(n_mode);
        w_res.flags_out = n_flags;
        w_res.error_led = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_STOPPED;
            r_flags <= '0;
            r_last  <= '0;
            r_led   <= 1'b0;
        end else if (o_take) begin
            r_mode  <= n_mode;
            r_flags <= n_flags;
            r_last  <= n_last;
            r_led   <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q[r_wptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (o_take) r_wptr <= q_next(r_wptr);
            if (w_pop)  r_rptr <= q_next(r_rptr);
            if (o_take && !w_pop)      r_cnt <= r_cnt + Q_CNT_W'(1);
            else if (w_pop && !o_take) r_cnt <= r_cnt - Q_CNT_W'(1);
        end
    end

    assign empty    = (r_cnt == '0);
    assign o_result = r_q[r_rptr];

    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("mode register lost its one-hot code");
    a_led_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led == (r_mode == MODE_ERROR))
        else $error("LED out of step with error mode");
    a_stop_no_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> !(w_res.stop_motor && w_res.setpoint_valid))
        else $error("stop and setpoint in one result");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_cnt != '0))
        else $error("result queue empty after a take");

endmodule

FILE: test/motor_node_safety_supervisor_top_tb.sv
// Self-checking testbench of the motor node safety supervisor with a cycle-free predictor.
`timescale 1ns / 1ps
module motor_node_safety_supervisor_top_tb;
    import mnss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;

    localparam logic [2:0] CODE_SPARE_6 = 3'd6;
    localparam logic [2:0] CODE_SPARE_7 = 3'd7;
    localparam logic [1:0] KIND_DUTY     = 2'd0;
    localparam logic [1:0] KIND_VELOCITY = 2'd1;
    localparam logic [1:0] KIND_POSITION = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic [5:0]  encoder_error;
        logic [7:0]  driver_error;
        logic [15:0] temperature;
        logic [2:0]  action_code;
        logic [1:0]  control_kind;
        logic [31:0] command_value;
    } t_node_msg;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [1:0]           i_action;
    logic [31:0]          i_now_ms;
    logic [5:0]           i_encoder_error;
    logic [7:0]           i_driver_error;
    logic signed [15:0]   i_temperature;
    logic [2:0]           i_action_code;
    logic [1:0]           i_control_kind;
    logic signed [31:0]   i_command_value;
    logic                 empty;
    logic                 pop;
    logic [1:0]           o_mode;
    logic [15:0]          o_flags_out;
    logic                 o_error_led;
    logic                 o_stop_motor;
    logic                 o_setpoint_valid;
    logic [1:0]           o_setpoint_kind;
    logic signed [31:0]   o_setpoint_value;
    logic [2:0]           o_service_request;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    motor_node_safety_supervisor_top uut (.*);

    // predicted node state and configuration
    logic [1:0]         node_mode = MODE_CODE_STOPPED;
    logic [15:0]        node_flags = '0;
    logic [31:0]        node_last_cmd_ms = '0;
    logic               node_led = 1'b0;
    logic               cfg_ignore_enc = 1'b0;
    logic signed [15:0] cfg_heat_on = RST_OVERHEAT_ON;
    logic signed [15:0] cfg_heat_off = RST_OVERHEAT_OFF;
    logic [15:0]        cfg_timeout_ms = RST_TIMEOUT_MS;
    logic [15:0]        cfg_crit_mask = RST_CRIT_MASK;

    t_result    pending_results[$];
    t_result    want;
    int         fails = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         rx_hold_req = 0;
    int         rx_hold_left = 0;
    int         stall_cycles = 0;
    logic [31:0] ms_clock = '0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result supervise(input t_node_msg m);
        t_result     r;
        logic [15:0] f;
        logic [31:0] elapsed;
        r = '0;
        if (m.action == ACT_TICK) begin
            f = {m.driver_error, node_flags[FLAG_TIMEOUT], node_flags[FLAG_OVERHEAT],
                 cfg_ignore_enc ? 6'd0 : m.encoder_error};
            if (f[FLAG_OVERHEAT]) begin
                if ($signed(m.temperature) < cfg_heat_off) f[FLAG_OVERHEAT] = 1'b0;
            end else if ($signed(m.temperature) > cfg_heat_on) begin
                f[FLAG_OVERHEAT] = 1'b1;
            end
            elapsed = m.now_ms - node_last_cmd_ms;
            f[FLAG_TIMEOUT] = (elapsed > {16'd0, cfg_timeout_ms}) &&
                              (node_mode == MODE_CODE_RUNNING);
            node_flags = f;
            if (node_mode == MODE_CODE_RUNNING) begin
                if (f != '0) begin
                    r.stop_motor = 1'b1;
                    if ((f & cfg_crit_mask) != '0) begin
                        node_led = 1'b1;
                        node_mode = MODE_CODE_ERROR;
                    end
                end
            end else if (node_mode == MODE_CODE_ERROR) begin
                if ((f & cfg_crit_mask) == '0) begin
                    node_led = 1'b0;
                    node_mode = MODE_CODE_RUNNING;
                    node_last_cmd_ms = m.now_ms;
                end
            end
        end else if (node_mode == MODE_CODE_RUNNING) begin
            if (m.action == ACT_ESTOP ||
                (m.action == ACT_REQ && m.action_code == CODE_DISARM)) begin
                r.stop_motor = 1'b1;
                node_mode = MODE_CODE_STOPPED;
            end else if (m.action == ACT_MOTOR) begin
                node_last_cmd_ms = m.now_ms;
                node_flags[FLAG_TIMEOUT] = 1'b0;
                if (m.control_kind != KIND_IGNORED) begin
                    r.setpoint_valid = 1'b1;
                    r.setpoint_kind = m.control_kind;
                    r.setpoint_value = m.command_value;
                end
            end
        end else if (node_mode == MODE_CODE_ERROR) begin
            if (m.action == ACT_REQ && m.action_code == CODE_DISARM) begin
                node_led = 1'b0;
                node_mode = MODE_CODE_STOPPED;
            end
        end else if (m.action == ACT_REQ) begin
            if (m.action_code == CODE_ARM) begin
                node_mode = MODE_CODE_RUNNING;
                node_last_cmd_ms = m.now_ms;
            end else if (m.action_code >= CODE_COMMIT && m.action_code <= CODE_RESET) begin
                r.service_request = m.action_code - 3'd1;
            end
        end
        r.mode = node_mode;
        r.flags_out = node_flags;
        r.error_led = node_led;
        return r;
    endfunction

    function automatic t_node_msg tick_msg(input logic [31:0] now, input logic [5:0] enc,
                                           input logic [7:0] drv, input logic [15:0] temp);
        t_node_msg m;
        m = '0;
        m.action = ACT_TICK;
        m.now_ms = now;
        m.encoder_error = enc;
        m.driver_error = drv;
        m.temperature = temp;
        return m;
    endfunction

    function automatic t_node_msg ctl_msg(input logic [1:0] act, input logic [31:0] now,
                                          input logic [2:0] code, input logic [1:0] kind,
                                          input logic [31:0] value);
        t_node_msg m;
        m = '0;
        m.action = act;
        m.now_ms = now;
        m.action_code = code;
        m.control_kind = kind;
        m.command_value = value;
        return m;
    endfunction

    function automatic t_node_msg random_msg();
        t_node_msg m;
        int        r;
        r = $urandom_range(0, 99);
        if (r < 70) ms_clock = ms_clock + $urandom_range(0, 200);
        else if (r < 90) ms_clock = ms_clock + $urandom_range(0, 2 * cfg_timeout_ms + 2);
        else if (r < 97) ms_clock = ms_clock + cfg_timeout_ms + $urandom_range(0, 1);
        else ms_clock = $urandom();
        m.now_ms = ms_clock;
        m.encoder_error = ($urandom_range(0, 99) < 12) ? 6'($urandom()) : 6'd0;
        m.driver_error = ($urandom_range(0, 99) < 12) ? 8'($urandom()) : 8'd0;
        if ($urandom_range(0, 99) < 80) begin
            m.temperature = node_flags[FLAG_OVERHEAT] ?
                16'(int'(cfg_heat_off) + int'($urandom_range(0, 8)) - 4) :
                16'(int'(cfg_heat_on) + int'($urandom_range(0, 8)) - 4);
        end else begin
            m.temperature = 16'($urandom());
        end
        m.action_code = 3'($urandom_range(0, 7));
        m.control_kind = 2'($urandom_range(0, 3));
        m.command_value = $urandom();
        m.action = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        case (node_mode)
            MODE_CODE_STOPPED: begin
                if (r < 45) begin
                    m.action = ACT_REQ;
                    m.action_code = CODE_ARM;
                end else if (r < 65) begin
                    m.action = ACT_TICK;
                end
            end
            MODE_CODE_RUNNING: begin
                if (r < 35) m.action = ACT_MOTOR;
                else if (r < 80) m.action = ACT_TICK;
                else if (r < 88) m.action = ACT_ESTOP;
                else m.action = ACT_REQ;
            end
            default: begin
                if (r < 60) begin
                    m.action = ACT_TICK;
                end else if (r < 80) begin
                    m.action = ACT_REQ;
                    m.action_code = CODE_DISARM;
                end
            end
        endcase
        return m;
    endfunction

    task automatic send_msg(input t_node_msg m);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_action <= m.action;
        i_now_ms <= m.now_ms;
        i_encoder_error <= m.encoder_error;
        i_driver_error <= m.driver_error;
        i_temperature <= m.temperature;
        i_action_code <= m.action_code;
        i_control_kind <= m.control_kind;
        i_command_value <= m.command_value;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        pending_results.push_back(supervise(m));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_IGNORE_ENC:   cfg_ignore_enc = data[0];
            CFG_OVERHEAT_ON:  cfg_heat_on = data;
            CFG_OVERHEAT_OFF: cfg_heat_off = data;
            CFG_TIMEOUT_MS:   cfg_timeout_ms = data;
            CFG_CRIT_MASK:    cfg_crit_mask = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic ign, input logic [15:0] heat_on,
                               input logic [15:0] heat_off, input logic [15:0] timeout_ms,
                               input logic [15:0] crit);
        wait_for_results();
        write_reg(CFG_IGNORE_ENC, {15'd0, ign});
        write_reg(CFG_OVERHEAT_ON, heat_on);
        write_reg(CFG_OVERHEAT_OFF, heat_off);
        write_reg(CFG_TIMEOUT_MS, timeout_ms);
        write_reg(CFG_CRIT_MASK, crit);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_msg(random_msg());
    endtask

    task automatic test_directed();
        send_msg(tick_msg(32'd0, 6'd0, 8'd0, 16'd0));
        send_msg(tick_msg(32'd1, 6'h3F, 8'hFF, 16'h7FFF));
        send_msg(tick_msg(32'd2, 6'd0, 8'd0, 16'h8000));
        send_msg(ctl_msg(ACT_ESTOP, 32'd3, CODE_ARM, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_MOTOR, 32'd4, CODE_ARM, KIND_DUTY, 32'h7FFF_FFFF));
        send_msg(ctl_msg(ACT_REQ, 32'd5, CODE_COMMIT, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'd6, CODE_RESTORE, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'd7, CODE_FACTORY, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'd8, CODE_RESET, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'd9, CODE_SPARE_6, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'd10, CODE_SPARE_7, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'd11, CODE_DISARM, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'hFFFF_FF00, CODE_ARM, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_MOTOR, 32'hFFFF_FF10, CODE_ARM, KIND_DUTY, 32'h8000_0000));
        send_msg(ctl_msg(ACT_MOTOR, 32'hFFFF_FF20, CODE_ARM, KIND_VELOCITY, 32'd12345));
        send_msg(ctl_msg(ACT_MOTOR, 32'hFFFF_FF30, CODE_ARM, KIND_POSITION, 32'hFFFF_FFFF));
        send_msg(ctl_msg(ACT_MOTOR, 32'hFFFF_FF40, CODE_ARM, KIND_IGNORED, 32'h1234_5678));
        send_msg(tick_msg(32'h0000_0100, 6'd0, 8'd0, 16'd0));
        send_msg(tick_msg(32'h0000_0400, 6'd0, 8'd0, 16'd0));
        send_msg(ctl_msg(ACT_REQ, 32'h0000_0450, CODE_ARM, KIND_DUTY, 32'd0));
        send_msg(tick_msg(32'h0000_0500, 6'd0, 8'd0, 16'd0));
        send_msg(ctl_msg(ACT_REQ, 32'h0000_0510, CODE_RESET, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_ESTOP, 32'h0000_0520, CODE_ARM, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'h0000_0600, CODE_ARM, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'h0000_0610, CODE_DISARM, KIND_DUTY, 32'd0));
        send_msg(ctl_msg(ACT_REQ, 32'h0000_0700, CODE_ARM, KIND_DUTY, 32'd0));
        send_msg(tick_msg(32'h0000_0710, 6'd0, 8'h01, 16'd0));
        send_msg(ctl_msg(ACT_REQ, 32'h0000_0720, CODE_DISARM, KIND_DUTY, 32'd0));
        ms_clock = 32'h0000_0800;
    endtask

    task automatic test_backpressure();
        rx_hold_req = 1;
        run_random(40);
        wait_for_results();
    endtask

    task automatic test_config_extremes();
        load_config(1'b1, 16'h7FFF, 16'h8000, 16'd0, 16'h0000);
        run_random(200);
        load_config(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0040);
        run_random(200);
    endtask

    task automatic test_config_random();
        repeat (3) begin
            load_config(1'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom_range(0, 3000)), 16'($urandom()));
            run_random(100);
        end
        load_config(1'b0, RST_OVERHEAT_ON, RST_OVERHEAT_OFF, RST_TIMEOUT_MS, RST_CRIT_MASK);
        run_random(100);
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] got);
        if (got !== expv) begin
            $error("%s: expected %0h, actual %0h", name, expv, got);
            fails++;
        end
    endtask

    // receiver: random pop, with a long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            pop <= 1'b0;
        end else if (rx_hold_req != 0) begin
            rx_hold_req = 0;
            rx_hold_left = RX_HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation pending");
                fails++;
            end else begin
                want = pending_results.pop_front();
                check_field("mode", want.mode, o_mode);
                check_field("flags_out", want.flags_out, o_flags_out);
                check_field("error_led", want.error_led, o_error_led);
                check_field("stop_motor", want.stop_motor, o_stop_motor);
                check_field("setpoint_valid", want.setpoint_valid, o_setpoint_valid);
                check_field("setpoint_kind", want.setpoint_kind, o_setpoint_kind);
                check_field("setpoint_value", want.setpoint_value, o_setpoint_value);
                check_field("service_request", want.service_request, o_service_request);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_action = ACT_TICK;
        i_now_ms = '0;
        i_encoder_error = '0;
        i_driver_error = '0;
        i_temperature = '0;
        i_action_code = CODE_ARM;
        i_control_kind = KIND_DUTY;
        i_command_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IGNORE_ENC;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 30;
        rx_idle_pct = 50;
        test_directed();
        run_random(250);
        test_backpressure();

        tx_idle_pct = 50;
        rx_idle_pct = 30;
        test_config_extremes();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_config_random();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mnss_pkg.sv
rtl/core/mnss_front.sv
rtl/core/mnss_back.sv
rtl/core/motor_node_safety_supervisor_top.sv
test/motor_node_safety_supervisor_top_tb.sv
